[hw/rtl/lzo1x_stream_decompressor_defines.svh]
// assertion macros for the lzo1x decompressor rtl
// no dependencies; simulation builds see the checks, synthesis sees nothing
`ifndef LZO1X_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZO1X_STREAM_DECOMPRESSOR_DEFINES_SVH
`ifndef SYNTHESIS
`define LZO_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lzo1x check failed");
`define LZO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzo1x check failed");
`else
`define LZO_ASSERT(lbl, clk, rst, prop)
`define LZO_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/lzo_pkg.sv]
// shared types, constants and helpers for the lzo1x decompressor
// no dependencies
package lzo_pkg;

  localparam int HISTORY_DEPTH = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int DRAIN_BURST   = 64;
  localparam int BURST_W       = (DRAIN_BURST > 1) ? $clog2(DRAIN_BURST) : 1;

  localparam logic CMD_FEED  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int ERR_DEPLETED = 0;
  localparam int ERR_FULL     = 1;
  localparam int ERR_BACKPTR  = 2;
  localparam int ERR_BAD      = 3;

  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  typedef struct packed {
    logic feed;       // consume one compressed byte
    logic status;     // empty drain: status beat only
    logic rd;         // read history at copy source
    logic copy;       // write copied byte and emit it
    logic last_beat;  // copy beat closes the drain
  } dp_cmd_t;

  typedef struct packed {
    logic match_pending;
    logic match_one;
    logic out_free;
  } dp_stat_t;

  function automatic logic [23:0] sat24(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? MAX24 : s[23:0];
  endfunction

endpackage

[hw/rtl/lzo1x_stream_decompressor.sv]
// lzo1x decompressor: the result beat of a feed or an empty drain is registered
// in the next cycle. a drain emits up to 64 pending match bytes; each beat is a
// registered read of the history ring, then a write and emit on a free output.
// the next item is taken once the drain ends and the output register is free.
// rst is synchronous: parser, counters and flags clear, limit returns to max;
// the history ring is not cleared and needs no pass after reset.
module lzo1x_stream_decompressor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        feed_refused,
  output logic        done_res,
  output logic [3:0]  error_flags,
  output logic [23:0] space_left
);

  lzo_pkg::dp_cmd_t  cmd;
  lzo_pkg::dp_stat_t stat;

  lzo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzo_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_byte      (in_byte),
    .last_byte    (last_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .feed_refused (feed_refused),
    .done_res     (done_res),
    .error_flags  (error_flags),
    .space_left   (space_left)
  );

endmodule

[hw/rtl/lzo_ctrl.sv]
// sequencer for feed, status and drain beats of the lzo1x decompressor
// depends on lzo_pkg and the assertion macro header
`include "lzo1x_stream_decompressor_defines.svh"
module lzo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  lzo_pkg::dp_stat_t stat,
  output lzo_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EMIT} state_t;

  state_t                      state;
  logic [lzo_pkg::BURST_W-1:0] cnt;
  logic                        accept;
  logic                        end_burst;

  assign in_stall  = !(state == S_IDLE && stat.out_free);
  assign accept    = in_valid && !in_stall;
  assign end_burst = stat.match_one ||
                     (cnt == lzo_pkg::BURST_W'(lzo_pkg::DRAIN_BURST - 1));

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.feed   = accept && (command == lzo_pkg::CMD_FEED);
        cmd.status = accept && (command == lzo_pkg::CMD_DRAIN) && !stat.match_pending;
      end
      S_RD: cmd.rd = 1'b1;
      S_EMIT: begin
        cmd.copy      = stat.out_free;
        cmd.last_beat = end_burst;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && command == lzo_pkg::CMD_DRAIN && stat.match_pending) begin
            state <= S_RD;
            cnt   <= '0;
          end
        end
        S_RD: state <= S_EMIT;
        S_EMIT: begin
          if (stat.out_free) begin
            state <= end_burst ? S_IDLE : S_RD;
            cnt   <= cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LZO_ASSERT(a_busy_stalls, clk, rst, (state != S_IDLE) |-> in_stall)
  `LZO_ASSERT_NEXT(a_rd_then_emit, clk, rst, state == S_RD, state == S_EMIT)
  `LZO_ASSERT(a_copy_pending, clk, rst, cmd.copy |-> stat.match_pending)

endmodule

[hw/rtl/lzo_datapath.sv]
// parser state, history ring and output register of the lzo1x decompressor
// depends on lzo_pkg
module lzo_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [23:0]       cfg_data,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  input  lzo_pkg::dp_cmd_t  cmd,
  output lzo_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              run_last,
  output logic              feed_refused,
  output logic              done_res,
  output logic [3:0]        error_flags,
  output logic [23:0]       space_left
);

  typedef enum logic [2:0] {
    PH_FIRST, PH_INSTR, PH_AFTER_LIT, PH_LEN_EXT, PH_LIT, PH_DIST1, PH_DIST2, PH_DIST_SHORT
  } phase_t;

  logic [7:0] hist [lzo_pkg::HISTORY_DEPTH];
  logic [7:0] rdata;

  logic [23:0] limit;
  phase_t      phase, phase_next;
  logic [7:0]  instr, instr_next;
  logic [23:0] len_acc, len_acc_next;
  logic [7:0]  dist_acc, dist_acc_next;
  logic        amm, amm_next;
  logic [23:0] lit_left, lit_left_next;
  logic [23:0] match_left, match_left_next;
  logic [15:0] mdist, mdist_next;
  logic [24:0] bw, bw_next;
  logic [3:0]  err, err_next;
  logic        fin, fin_next;

  logic [23:0] sp_cur, sp_next;
  logic        got, refused, wr_en, load;
  logic [7:0]  wr_data;
  logic        instr_go, instr_al, ld_go, sm_go;
  logic [7:0]  instr_x;
  logic [23:0] ld_cnt, sm_len, mask;
  logic [24:0] sm_back, back;
  logic [1:0]  sm_trail;

  assign sp_cur = (bw >= {1'b0, limit}) ? '0 : 24'({1'b0, limit} - bw);
  assign sp_next = (bw_next >= {1'b0, limit}) ? '0 : 24'({1'b0, limit} - bw_next);

  assign stat.match_pending = (match_left != '0);
  assign stat.match_one     = (match_left == 24'd1);
  assign stat.out_free      = !out_valid || !out_stall;

  always_comb begin
    phase_next = phase;  instr_next = instr;  len_acc_next = len_acc;
    dist_acc_next = dist_acc;  amm_next = amm;  lit_left_next = lit_left;
    match_left_next = match_left;  mdist_next = mdist;  bw_next = bw;
    err_next = err;  fin_next = fin;
    got = 1'b0;  refused = 1'b0;  wr_en = 1'b0;  wr_data = in_byte;
    instr_go = 1'b0;  instr_al = 1'b0;  instr_x = in_byte;
    ld_go = 1'b0;  ld_cnt = '0;  sm_go = 1'b0;  sm_len = '0;  sm_back = '0;
    sm_trail = '0;  mask = '0;  back = '0;

    if (cmd.copy) begin
      wr_en = 1'b1;
      wr_data = rdata;
      bw_next = bw + 1'b1;
      match_left_next = match_left - 1'b1;
    end else if (cmd.feed) begin
      if (match_left != '0) begin
        refused = 1'b1;
      end else if (!fin) begin
        case (phase)
          PH_FIRST: begin
            if (in_byte > 8'd17) begin
              lit_left_next = 24'(in_byte - 8'd17);
              amm_next = (in_byte - 8'd17) < 8'd4;
              phase_next = PH_LIT;
            end else begin
              instr_go = 1'b1;
            end
          end
          PH_INSTR: instr_go = 1'b1;
          PH_AFTER_LIT: begin
            instr_go = 1'b1;
            instr_al = 1'b1;
          end
          PH_LEN_EXT: begin
            if (in_byte == 8'd0) begin
              len_acc_next = lzo_pkg::sat24(len_acc, 24'd255);
            end else begin
              mask = (instr >= 8'd32) ? 24'd31 : ((instr >= 8'd16) ? 24'd7 : 24'd15);
              ld_go = 1'b1;
              ld_cnt = lzo_pkg::sat24(len_acc, mask + 24'(in_byte));
            end
          end
          PH_LIT: begin
            if (sp_cur == '0) begin
              err_next[lzo_pkg::ERR_FULL] = 1'b1;
              fin_next = 1'b1;
            end else begin
              got = 1'b1;
              wr_en = 1'b1;
              bw_next = bw + 1'b1;
              lit_left_next = (lit_left != '0) ? lit_left - 1'b1 : '0;
              if (lit_left_next == '0) phase_next = amm ? PH_INSTR : PH_AFTER_LIT;
            end
          end
          PH_DIST1: begin
            dist_acc_next = in_byte;
            phase_next = PH_DIST2;
          end
          PH_DIST2: begin
            sm_len = lzo_pkg::sat24(len_acc, 24'd2);
            sm_trail = dist_acc[1:0];
            if (instr >= 8'd32) begin
              sm_back = (25'(in_byte) << 6) + 25'(dist_acc[7:2]) + 25'd1;
              sm_go = 1'b1;
            end else begin
              back = 25'(1 << 14) + (25'(instr[3]) << 14) + (25'(in_byte) << 6)
                   + 25'(dist_acc[7:2]);
              if (back == 25'(1 << 14)) begin
                // end marker
                if (len_acc != 24'd1) err_next[lzo_pkg::ERR_BAD] = 1'b1;
                fin_next = 1'b1;
              end else begin
                sm_back = back;
                sm_go = 1'b1;
              end
            end
          end
          default: begin
            sm_go = 1'b1;
            sm_trail = instr[1:0];
            if (instr >= 8'd64) begin
              sm_back = (25'(in_byte) << 3) + 25'(instr[4:2]) + 25'd1;
              sm_len = 24'(instr[7:5]) + 24'd1;
            end else if (amm) begin
              sm_back = (25'(in_byte) << 2) + 25'(instr[3:2]) + 25'd1;
              sm_len = 24'd2;
            end else begin
              sm_back = 25'd2049 + (25'(in_byte) << 2) + 25'(instr[3:2]);
              sm_len = 24'd3;
            end
          end
        endcase

        if (instr_go) begin
          instr_next = instr_x;
          if (instr_x >= 8'd64) begin
            phase_next = PH_DIST_SHORT;
          end else if (instr_x >= 8'd32) begin
            len_acc_next = '0;
            if (instr_x[4:0] != '0) begin
              ld_go = 1'b1;
              ld_cnt = 24'(instr_x[4:0]);
            end else phase_next = PH_LEN_EXT;
          end else if (instr_x >= 8'd16) begin
            len_acc_next = '0;
            if (instr_x[2:0] != '0) begin
              ld_go = 1'b1;
              ld_cnt = 24'(instr_x[2:0]);
            end else phase_next = PH_LEN_EXT;
          end else if (instr_al || amm) begin
            phase_next = PH_DIST_SHORT;
          end else begin
            len_acc_next = '0;
            if (instr_x[3:0] != '0) begin
              ld_go = 1'b1;
              ld_cnt = 24'(instr_x[3:0]);
            end else phase_next = PH_LEN_EXT;
          end
        end

        if (ld_go) begin
          if (instr_next < 8'd16) begin
            lit_left_next = lzo_pkg::sat24(ld_cnt, 24'd3);
            phase_next = PH_LIT;
          end else begin
            len_acc_next = ld_cnt;
            phase_next = PH_DIST1;
          end
        end

        if (sm_go) begin
          if (sm_back > bw) begin
            err_next[lzo_pkg::ERR_BACKPTR] = 1'b1;
            fin_next = 1'b1;
          end else begin
            if (sm_len > sp_cur) begin
              // cut to the space left, stop after the drain
              sm_len = sp_cur;
              err_next[lzo_pkg::ERR_FULL] = 1'b1;
              fin_next = 1'b1;
            end
            match_left_next = sm_len;
            mdist_next = sm_back[15:0];
            amm_next = (sm_trail != '0);
            if (sm_trail != '0) begin
              lit_left_next = 24'(sm_trail);
              phase_next = PH_LIT;
            end else phase_next = PH_INSTR;
          end
        end

        if (last_byte && !fin_next) begin
          err_next[lzo_pkg::ERR_DEPLETED] = 1'b1;
          fin_next = 1'b1;
        end
      end
    end
  end

  assign load = cmd.feed || cmd.status || cmd.copy;

  // history ring: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) hist[bw[lzo_pkg::HIST_AW-1:0]] <= wr_data;
    if (cmd.rd) rdata <= hist[bw[lzo_pkg::HIST_AW-1:0] - mdist[lzo_pkg::HIST_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= lzo_pkg::MAX24;
      phase <= PH_FIRST;
      instr <= '0;
      len_acc <= '0;
      dist_acc <= '0;
      amm <= 1'b0;
      lit_left <= '0;
      match_left <= '0;
      mdist <= '0;
      bw <= '0;
      err <= '0;
      fin <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      phase <= phase_next;
      instr <= instr_next;
      len_acc <= len_acc_next;
      dist_acc <= dist_acc_next;
      amm <= amm_next;
      lit_left <= lit_left_next;
      match_left <= match_left_next;
      mdist <= mdist_next;
      bw <= bw_next;
      err <= err_next;
      fin <= fin_next;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= cmd.copy ? rdata : (got ? in_byte : 8'd0);
      byte_valid   <= cmd.copy || got;
      run_last     <= cmd.copy ? cmd.last_beat : 1'b1;
      feed_refused <= refused;
      done_res     <= fin_next;
      error_flags  <= err_next;
      space_left   <= sp_next;
    end
  end

endmodule
